// ----- sv/smrm_pkg.sv -----
`timescale 1ns / 1ps

package smrm_pkg;

  // Channel key: {cell_type, cell_number, node_num}.
  localparam int unsigned KeyW    = 40;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RateW   = 32;
  localparam int unsigned VoltW   = 16;
  // The dividend is ticks_per_second scaled by 256.
  localparam int unsigned FracW   = 8;
  localparam int unsigned NumW    = RateW + FracW;
  localparam int unsigned DivCntW = 6;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_SPIKE_THRESHOLD  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_SECOND = 2'd1;

  localparam logic signed [VoltW-1:0] THRESH_RESET = -16'sd4000;
  localparam logic [TimeW-1:0]        TPS_RESET    = 32'd1000000;
  localparam logic [15:0]             NODE_NONE    = 16'hFFFF;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic             spike;
    logic             armed;
    logic [TimeW-1:0] interval;
    logic [RateW-1:0] peak;
  } smrm_tok_t;

  // Peak write-back broadcast to the cell row.
  typedef struct packed {
    logic             en;
    logic [RateW-1:0] peak;
  } smrm_wb_t;

endpackage

// ----- sv/smrm_if.sv -----
`timescale 1ns / 1ps

interface smrm_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         cell_type;
  logic [15:0]        cell_number;
  logic signed [15:0] node_num;
  logic signed [15:0] voltage;
  logic [31:0]        timestamp;

  modport source (
    output valid, cell_type, cell_number, node_num, voltage, timestamp,
    input  ready
  );
  modport sink (
    input  valid, cell_type, cell_number, node_num, voltage, timestamp,
    output ready
  );
endinterface

interface smrm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] spike_rate;
  logic [31:0] peak_rate;
  logic        spike_seen;
  logic [2:0]  slot_index;
  logic        no_slot;

  modport source (
    output valid, spike_rate, peak_rate, spike_seen, slot_index, no_slot,
    input  ready
  );
  modport sink (
    input  valid, spike_rate, peak_rate, spike_seen, slot_index, no_slot,
    output ready
  );
endinterface

// ----- sv/smrm_cell.sv -----
`timescale 1ns / 1ps

module smrm_cell #(
  parameter int unsigned SlotW = 3,
  parameter int unsigned Index = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [smrm_pkg::KeyW-1:0]        key_i,
  input  logic signed [smrm_pkg::VoltW-1:0] volt_i,
  input  logic signed [smrm_pkg::VoltW-1:0] thr_i,
  input  logic [smrm_pkg::TimeW-1:0]       now_i,
  input  smrm_pkg::smrm_tok_t              tok_i,
  input  logic [SlotW-1:0]                 idx_i,
  input  smrm_pkg::smrm_wb_t               wb_i,
  input  logic [SlotW-1:0]                 wb_idx_i,
  output smrm_pkg::smrm_tok_t              tok_o,
  output logic [SlotW-1:0]                 idx_o
);

  logic                         used_q;
  logic                         above_q;
  logic                         armed_q;
  logic [smrm_pkg::RateW-1:0]   max_q;
  logic [smrm_pkg::KeyW-1:0]    key_q;
  logic [smrm_pkg::TimeW-1:0]   last_q;
  smrm_pkg::smrm_tok_t          tok_q, tok_d;
  logic [SlotW-1:0]             idx_q, idx_d;
  logic                         key_hit, take, vh, spike;

  // An unused cell takes any key that no earlier cell claimed; cells fill in
  // order, so this is always the next free slot.
  always_comb begin
    key_hit = used_q ? (key_q == key_i) : 1'b1;
    take    = tok_i.vld & ~tok_i.hit & key_hit;
    vh      = volt_i > thr_i;
    spike   = vh & ~above_q;
    tok_d   = tok_i;
    idx_d   = idx_i;
    if (take) begin
      tok_d.hit      = 1'b1;
      tok_d.spike    = spike;
      tok_d.armed    = armed_q;
      tok_d.interval = now_i - last_q;
      tok_d.peak     = max_q;
      idx_d          = SlotW'(Index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      idx_q   <= '0;
      used_q  <= 1'b0;
      above_q <= 1'b0;
      armed_q <= 1'b0;
      max_q   <= '0;
    end else begin
      tok_q <= tok_d;
      idx_q <= idx_d;
      if (take) begin
        used_q  <= 1'b1;
        above_q <= vh;
        if (spike) begin
          armed_q <= 1'b1;
        end
      end
      if (wb_i.en && (wb_idx_i == SlotW'(Index))) begin
        max_q <= wb_i.peak;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !used_q) begin
      key_q <= key_i;
    end
    if (take && spike) begin
      last_q <= now_i;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

// ----- sv/smrm_div.sv -----
`timescale 1ns / 1ps

module smrm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [smrm_pkg::NumW-1:0]  dividend_i,
  input  logic [smrm_pkg::TimeW-1:0] divisor_i,
  output logic                       done_o,
  output logic [smrm_pkg::NumW-1:0]  quotient_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [smrm_pkg::DivCntW-1:0] cnt_q;
  logic [smrm_pkg::TimeW-1:0]   den_q;
  logic [smrm_pkg::TimeW-1:0]   rem_q, rem_d;
  logic [smrm_pkg::NumW-1:0]    quo_q;
  logic [smrm_pkg::TimeW:0]     trial;
  logic                         qbit;

  // Restoring division, one quotient bit per cycle; the remainder always
  // stays below the divisor, so it fits in the divisor's width.
  always_comb begin
    trial = {rem_q, quo_q[smrm_pkg::NumW-1]};
    qbit  = trial >= {1'b0, den_q};
    if (qbit) begin
      rem_d = smrm_pkg::TimeW'(trial - {1'b0, den_q});
    end else begin
      rem_d = smrm_pkg::TimeW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= smrm_pkg::DivCntW'(smrm_pkg::NumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[smrm_pkg::NumW-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- sv/multi_channel_spike_rate_meter_unit.sv -----
`timescale 1ns / 1ps

// Multi-channel spike rate meter. Each input word names a channel by
// {cell_type, cell_number, node_num} and carries a voltage sample and a
// timestamp. The channel is looked up in a row of SLOTS cells, each owning
// one table slot; a new channel takes the next free cell, and a node of -1
// or a full table gives a word with no_slot set and everything else zero.
// A rising crossing of spike_threshold is a spike; the first spike of a
// channel only arms it, and each later one gives ticks_per_second * 256 /
// interval (Hz with 8 fraction bits, saturating, all ones for a zero
// interval). peak_rate is the channel's largest rate so far. The block takes
// one word at a time: after acceptance its token walks the cell row, and when
// a rate is computed the bit-serial divider, which produces one quotient bit
// per cycle, runs before the result word is presented. The next input word
// can be accepted in the same cycle that the result is first presented.
// A finished result waits in an output register, and the next input word is
// accepted while it waits. Configuration is to be written only while idle;
// the user must keep to this, as the block itself does not enforce it.

module multi_channel_spike_rate_meter_unit #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smrm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [smrm_pkg::CfgDataW-1:0]   cfg_data_i,
  smrm_in_if.sink                         in_i,
  smrm_out_if.source                      out_o
);

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic signed [smrm_pkg::VoltW-1:0] thr_q;
  logic [smrm_pkg::TimeW-1:0]        tps_q;

  // The word being worked on.
  logic [smrm_pkg::KeyW-1:0]         key_q;
  logic signed [smrm_pkg::VoltW-1:0] volt_q;
  logic [smrm_pkg::TimeW-1:0]        now_q;
  logic                              nochan_q;
  logic                              launch_q;

  // Token as it leaves the last cell.
  smrm_pkg::smrm_tok_t               res_q;
  logic [SlotW-1:0]                  res_idx_q;
  logic [smrm_pkg::RateW-1:0]        rate_q, rate_d;

  // Output register.
  logic                              out_vld_q;
  logic [smrm_pkg::RateW-1:0]        out_rate_q;
  logic [smrm_pkg::RateW-1:0]        out_peak_q;
  logic                              out_spike_q;
  logic [2:0]                        out_slot_q;
  logic                              out_none_q;

  smrm_pkg::smrm_tok_t               tok [SLOTS+1];
  logic [SlotW-1:0]                  idx [SLOTS+1];
  smrm_pkg::smrm_wb_t                wb;

  logic                              accept;
  logic                              tok_done;
  logic                              need_div;
  logic                              div_start;
  logic                              div_done;
  logic [smrm_pkg::NumW-1:0]         quotient;
  logic                              can_load;
  logic                              no_slot;
  logic [smrm_pkg::RateW-1:0]        new_peak;
  logic [SlotW+2:0]                  idx_ext;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= smrm_pkg::THRESH_RESET;
      tps_q <= smrm_pkg::TPS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smrm_pkg::CFG_SPIKE_THRESHOLD:  thr_q <= cfg_data_i[smrm_pkg::VoltW-1:0];
        smrm_pkg::CFG_TICKS_PER_SECOND: tps_q <= cfg_data_i[smrm_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= {in_i.cell_type, in_i.cell_number, in_i.node_num};
      volt_q   <= in_i.voltage;
      now_q    <= in_i.timestamp;
      nochan_q <= (in_i.node_num == smrm_pkg::NODE_NONE);
    end
  end

  // The token enters the row already marked as taken when there is no
  // channel, so no cell reacts to it.
  always_comb begin
    tok[0]          = '0;
    tok[0].vld      = launch_q;
    tok[0].hit      = nochan_q;
    idx[0]          = '0;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    smrm_cell #(
      .SlotW (SlotW),
      .Index (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .key_i    (key_q),
      .volt_i   (volt_q),
      .thr_i    (thr_q),
      .now_i    (now_q),
      .tok_i    (tok[g]),
      .idx_i    (idx[g]),
      .wb_i     (wb),
      .wb_idx_i (res_idx_q),
      .tok_o    (tok[g+1]),
      .idx_o    (idx[g+1])
    );
  end

  assign tok_done  = (state_q == ST_WALK) & tok[SLOTS].vld;
  assign need_div  = ~nochan_q & tok[SLOTS].hit & tok[SLOTS].spike & tok[SLOTS].armed;
  assign div_start = tok_done & need_div & (tok[SLOTS].interval != '0);

  smrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({tps_q, {smrm_pkg::FracW{1'b0}}}),
    .divisor_i  (tok[SLOTS].interval),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign can_load = ~out_vld_q | out_o.ready;
  assign no_slot  = nochan_q | ~res_q.hit;
  assign new_peak = (rate_q > res_q.peak) ? rate_q : res_q.peak;
  assign idx_ext  = {3'b000, res_idx_q};

  always_comb begin
    wb.en   = (state_q == ST_FIN) & can_load & ~no_slot;
    wb.peak = new_peak;
  end

  always_comb begin
    state_d = state_q;
    rate_d  = rate_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok_done) begin
          if (!need_div) begin
            rate_d  = '0;
            state_d = ST_FIN;
          end else if (tok[SLOTS].interval == '0) begin
            rate_d  = '1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (quotient[smrm_pkg::NumW-1:smrm_pkg::RateW] != '0) begin
            rate_d = '1;
          end else begin
            rate_d = quotient[smrm_pkg::RateW-1:0];
          end
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      launch_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept;
      if ((state_q == ST_FIN) && can_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
    if (tok_done) begin
      res_q     <= tok[SLOTS];
      res_idx_q <= idx[SLOTS];
    end
    if ((state_q == ST_FIN) && can_load) begin
      if (no_slot) begin
        out_rate_q  <= '0;
        out_peak_q  <= '0;
        out_spike_q <= 1'b0;
        out_slot_q  <= '0;
        out_none_q  <= 1'b1;
      end else begin
        out_rate_q  <= rate_q;
        out_peak_q  <= new_peak;
        out_spike_q <= res_q.spike;
        out_slot_q  <= idx_ext[2:0];
        out_none_q  <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.spike_rate = out_rate_q;
  assign out_o.peak_rate  = out_peak_q;
  assign out_o.spike_seen = out_spike_q;
  assign out_o.slot_index = out_slot_q;
  assign out_o.no_slot    = out_none_q;

endmodule
